### rtl/core/pddm_pkg.sv
// pddm_pkg: shared types, constants, microprogram and arithmetic helpers
// for the pid differential drive mixer; no dependencies
package pddm_pkg;

	localparam int GAIN_W  = 27;
	localparam int SUM_W   = 24;
	localparam int MUL_A_W = 28;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int DRV_P_W = 20;
	localparam int STEP_W  = 4;

	localparam logic [GAIN_W-1:0] PROP_RST   = 27'd15099494;
	localparam logic [GAIN_W-1:0] INTEG_RST  = 27'd537;
	localparam logic [GAIN_W-1:0] DERIV_RST  = 27'd20971520;
	localparam logic [6:0]        TARGET_RST = 7'd10;
	localparam logic [7:0]        BASE_RST   = 8'd0;
	localparam logic [8:0]        SCALE_RST  = 9'd179;

	// register indexes on the config port
	localparam logic [2:0] REG_PROP   = 3'd0;
	localparam logic [2:0] REG_INTEG  = 3'd1;
	localparam logic [2:0] REG_DERIV  = 3'd2;
	localparam logic [2:0] REG_TARGET = 3'd3;
	localparam logic [2:0] REG_BASE   = 3'd4;
	localparam logic [2:0] REG_SCALE  = 3'd5;

	// multiplier operand selects
	localparam logic [1:0] A_PROP  = 2'd0;
	localparam logic [1:0] A_INTEG = 2'd1;
	localparam logic [1:0] A_DERIV = 2'd2;
	localparam logic [1:0] A_SCALE = 2'd3;

	localparam logic [2:0] B_ERR   = 3'd0;
	localparam logic [2:0] B_SUM   = 3'd1;
	localparam logic [2:0] B_DIFF  = 3'd2;
	localparam logic [2:0] B_PLUS  = 3'd3;
	localparam logic [2:0] B_MINUS = 3'd4;

	// accumulator operations
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// step conditions
	localparam logic [1:0] COND_NONE = 2'd0;
	localparam logic [1:0] COND_IN   = 2'd1;
	localparam logic [1:0] COND_OUT  = 2'd2;

	typedef struct packed {
		logic [1:0]        a_sel;
		logic [2:0]        b_sel;
		logic              mul_en;
		logic [1:0]        acc_op;
		logic              steer_en;
		logic              left_en;
		logic [1:0]        cond;
		logic              jump;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} hs_t;

	typedef struct packed {
		logic        [GAIN_W-1:0] prop;
		logic        [GAIN_W-1:0] integ;
		logic        [GAIN_W-1:0] deriv;
		logic        [6:0]        target;
		logic signed [7:0]        base;
		logic        [8:0]        scale;
	} cfg_t;

	typedef struct packed {
		logic signed [7:0] left;
		logic signed [7:0] right;
		logic signed [8:0] steer;
	} res_t;

	function automatic ctrl_t ctrl_word(logic [1:0] a, logic [2:0] b, logic m,
			logic [1:0] acc, logic st, logic lf, logic [1:0] cnd, logic j);
		ctrl_t c;
		c.a_sel    = a;
		c.b_sel    = b;
		c.mul_en   = m;
		c.acc_op   = acc;
		c.steer_en = st;
		c.left_en  = lf;
		c.cond     = cnd;
		c.jump     = j;
		c.target   = '0;
		return c;
	endfunction

	// microprogram: one control word per step
	function automatic ctrl_t pddm_program(logic [STEP_W-1:0] step);
		ctrl_t c;
		unique case (step)
			4'd0: c = ctrl_word(A_PROP, B_ERR, 1'b0, ACC_HOLD, 1'b0, 1'b0, COND_IN, 1'b0);
			4'd1: c = ctrl_word(A_PROP, B_ERR, 1'b1, ACC_HOLD, 1'b0, 1'b0, COND_NONE, 1'b0);
			4'd2: c = ctrl_word(A_INTEG, B_SUM, 1'b1, ACC_LOAD, 1'b0, 1'b0, COND_NONE, 1'b0);
			4'd3: c = ctrl_word(A_DERIV, B_DIFF, 1'b1, ACC_ADD, 1'b0, 1'b0, COND_NONE, 1'b0);
			4'd4: c = ctrl_word(A_PROP, B_ERR, 1'b0, ACC_ADD, 1'b0, 1'b0, COND_NONE, 1'b0);
			4'd5: c = ctrl_word(A_PROP, B_ERR, 1'b0, ACC_HOLD, 1'b1, 1'b0, COND_NONE, 1'b0);
			4'd6: c = ctrl_word(A_SCALE, B_PLUS, 1'b1, ACC_HOLD, 1'b0, 1'b0, COND_NONE, 1'b0);
			4'd7: c = ctrl_word(A_SCALE, B_MINUS, 1'b1, ACC_HOLD, 1'b0, 1'b1, COND_NONE,
				1'b0);
			4'd8: c = ctrl_word(A_PROP, B_ERR, 1'b0, ACC_HOLD, 1'b0, 1'b0, COND_OUT, 1'b1);
			default: c = ctrl_word(A_PROP, B_ERR, 1'b0, ACC_HOLD, 1'b0, 1'b0, COND_NONE,
				1'b1);
		endcase
		return c;
	endfunction

	// steer: divide by 2^24 toward zero, clamp to +-200
	function automatic logic signed [8:0] steer_of(logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-25:0] q;
		logic signed [8:0] r;
		t = a + (a[ACC_W-1] ? ACC_W'(24'hFFFFFF) : ACC_W'(0));
		q = t[ACC_W-1:24];
		if (q > 200)       r = 9'sd200;
		else if (q < -200) r = -9'sd200;
		else               r = q[8:0];
		return r;
	endfunction

	// drive: divide by 256 toward zero, clamp to +-100
	function automatic logic signed [7:0] drive_of(logic signed [DRV_P_W-1:0] p);
		logic signed [DRV_P_W-1:0] t;
		logic signed [DRV_P_W-9:0] q;
		logic signed [7:0] r;
		t = p + (p[DRV_P_W-1] ? DRV_P_W'(8'hFF) : DRV_P_W'(0));
		q = t[DRV_P_W-1:8];
		if (q > 100)       r = 8'sd100;
		else if (q < -100) r = -8'sd100;
		else               r = q[7:0];
		return r;
	endfunction

endpackage

### rtl/core/pddm_seq.sv
// pddm_seq: step counter and microprogram rom with conditional waits/jumps
// depends on pddm_pkg
module pddm_seq import pddm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  hs_t   hs,
	output ctrl_t ctrl
);

	logic [STEP_W-1:0] step_q;
	logic              advance;

	assign ctrl = pddm_program(step_q);

	always_comb begin
		unique case (ctrl.cond)
			COND_IN:  advance = hs.in_valid;
			COND_OUT: advance = hs.out_free;
			default:  advance = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (advance) begin
			step_q <= ctrl.jump ? ctrl.target : step_q + 1'b1;
		end
	end

endmodule

### rtl/core/pddm_dp.sv
// pddm_dp: error state, shared multiplier, accumulator and post-scaling
// depends on pddm_pkg
module pddm_dp import pddm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_t      ctrl,
	input  logic       take,
	input  logic [6:0] brightness,
	input  cfg_t       cfg,
	output res_t       res
);

	logic signed [7:0]         last_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [8:0]         diff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [8:0]         steer_q;
	logic signed [7:0]         left_q;

	logic signed [7:0]         err;
	logic signed [SUM_W+1:0]   sum_wide;
	logic signed [SUM_W-1:0]   sum_sat;
	logic signed [9:0]         plus;
	logic signed [9:0]         minus;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;

	assign err = $signed({1'b0, brightness}) - $signed({1'b0, cfg.target});
	assign sum_wide = (SUM_W+2)'(sum_q) + (SUM_W+2)'(err) + (SUM_W+2)'(last_q);

	always_comb begin
		if (sum_wide > (SUM_W+2)'(24'sh7FFFFF))        sum_sat = 24'sh7FFFFF;
		else if (sum_wide < -(SUM_W+2)'(25'sh0800000)) sum_sat = 24'sh800000;
		else                                            sum_sat = sum_wide[SUM_W-1:0];
	end

	assign plus  = 10'(cfg.base) + 10'(steer_q);
	assign minus = 10'(cfg.base) - 10'(steer_q);

	always_comb begin
		unique case (ctrl.a_sel)
			A_PROP:  mul_a = {1'b0, cfg.prop};
			A_INTEG: mul_a = {1'b0, cfg.integ};
			A_DERIV: mul_a = {1'b0, cfg.deriv};
			default: mul_a = {{(MUL_A_W-9){1'b0}}, cfg.scale};
		endcase
		unique case (ctrl.b_sel)
			B_ERR:   mul_b = MUL_B_W'(last_q);
			B_SUM:   mul_b = sum_q;
			B_DIFF:  mul_b = MUL_B_W'(diff_q);
			B_PLUS:  mul_b = MUL_B_W'(plus);
			default: mul_b = MUL_B_W'(minus);
		endcase
	end

	// error history: last_q holds the current error once the sample is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			sum_q  <= '0;
		end else if (take) begin
			last_q <= err;
			sum_q  <= sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			diff_q <= 9'(err) - 9'(last_q);
		if (ctrl.mul_en)
			prod_q <= mul_a * mul_b;
		unique case (ctrl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default:  acc_q <= acc_q;
		endcase
		if (ctrl.steer_en)
			steer_q <= steer_of(acc_q);
		if (ctrl.left_en)
			left_q <= drive_of(prod_q[DRV_P_W-1:0]);
	end

	assign res.left  = left_q;
	assign res.right = drive_of(prod_q[DRV_P_W-1:0]);
	assign res.steer = steer_q;

endmodule

### rtl/core/pid_differential_drive_mixer.sv
// pid_differential_drive_mixer: top level with config registers, input and
// output handshakes; depends on pddm_pkg, pddm_seq and pddm_dp
//
// usage
// - input stream s_*: one brightness sample per transfer (s_tdata[6:0])
// - output stream m_*: left drive, right drive and steer value per sample
// - config port cfg_we/cfg_addr/cfg_wdata: write only, one register per
//   cycle, to be used while no sample is in flight
// schedule
// - the result is offered once the microprogram reaches its last step and
//   the output register is free; the next sample can be taken only once the
//   result has been loaded, so only one sample is in flight at a time
// - the microprogram computes three products of the pid sum and two wheel
//   products in turn, sharing a single registered multiplier
// reset
// - arst_n clears the step counter, the error history, the output valid
//   flag and loads the default gains, set point, base speed and scale
// stalls
// - a result waits in the output register while m_tready is low; the
//   sequencer holds on its last step until the register is free, and
//   s_tready stays low until then
module pid_differential_drive_mixer import pddm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [6:0] brightness, [7] zero
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] left_drive, [15:8] right_drive,
	                               // [24:16] steer_value, [31:25] zero
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [26:0] cfg_wdata
);

	cfg_t  cfg_q;
	ctrl_t ctrl;
	hs_t   hs;
	res_t  res;
	res_t  out_q;
	logic  out_valid_q;
	logic  take;
	logic  out_free;
	logic  out_load;

	// config registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop   <= PROP_RST;
			cfg_q.integ  <= INTEG_RST;
			cfg_q.deriv  <= DERIV_RST;
			cfg_q.target <= TARGET_RST;
			cfg_q.base   <= BASE_RST;
			cfg_q.scale  <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PROP:   cfg_q.prop   <= cfg_wdata;
				REG_INTEG:  cfg_q.integ  <= cfg_wdata;
				REG_DERIV:  cfg_q.deriv  <= cfg_wdata;
				REG_TARGET: cfg_q.target <= cfg_wdata[6:0];
				REG_BASE:   cfg_q.base   <= cfg_wdata[7:0];
				REG_SCALE:  cfg_q.scale  <= cfg_wdata[8:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// handshake decode from the current control word
	assign s_tready = (ctrl.cond == COND_IN);
	assign take     = s_tready & s_tvalid;
	assign out_free = !out_valid_q | m_tready;
	assign out_load = (ctrl.cond == COND_OUT) & out_free;

	assign hs.in_valid = s_tvalid;
	assign hs.out_free = out_free;

	pddm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.hs     (hs),
		.ctrl   (ctrl)
	);

	pddm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.take       (take),
		.brightness (s_tdata[6:0]),
		.cfg        (cfg_q),
		.res        (res)
	);

	// output register, holds its transfer while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.steer, out_q.right, out_q.left};

endmodule

### rtl/core/pddm_checker.sv
// pddm_checker: port-level assertions for the pid differential drive mixer
// bound to the top level; no package dependency
module pddm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// one sample at a time: busy right after an input transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after a transfer");

	// a new result only comes while the input side is closed
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a sample in flight");

	// results stay within their clamps, padding zero
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[7:0]) <= 8'sd100) &&
			($signed(m_tdata[7:0]) >= -8'sd100) &&
			($signed(m_tdata[15:8]) <= 8'sd100) &&
			($signed(m_tdata[15:8]) >= -8'sd100) &&
			($signed(m_tdata[24:16]) <= 9'sd200) &&
			($signed(m_tdata[24:16]) >= -9'sd200) &&
			(m_tdata[31:25] == 7'd0))
		else $error("result outside its clamp");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind pid_differential_drive_mixer pddm_checker u_pddm_checker (.*);
